[design/mfi_pkg.sv]
package mfi_pkg;

    // Ring buffer geometry.
    localparam int BUF_DEPTH = 4096;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // Field and register widths.
    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 2;
    localparam int PERIOD_W = 16;
    localparam int PULSE_W  = 8;
    localparam int GAP_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAP_W;

    // Register values after reset.
    localparam logic [PERIOD_W-1:0] PERIOD_SHORT_RST  = 16'd288;
    localparam logic [PERIOD_W-1:0] PERIOD_MEDIUM_RST = 16'd432;
    localparam logic [PERIOD_W-1:0] PERIOD_LONG_RST   = 16'd576;
    localparam logic [PULSE_W-1:0]  PULSE_WIDTH_RST   = 8'd28;
    localparam logic [GAP_W-1:0]    GAP_PATTERN_RST   = 24'hA96A96;

    localparam logic [PERIOD_W-1:0] START_SHORT_RST  = 16'd260;
    localparam logic [PERIOD_W-1:0] START_MEDIUM_RST = 16'd404;
    localparam logic [PERIOD_W-1:0] START_LONG_RST   = 16'd548;

    // Interval codes.
    localparam logic [CODE_W-1:0] CODE_MEDIUM = 2'd2;
    localparam logic [CODE_W-1:0] CODE_LONG   = 2'd3;
    localparam logic [CODE_W-1:0] LAST_CODE_POS = 2'd3;

    // Gap pattern byte slots, most significant byte first.
    localparam logic [1:0] GAP_SLOT_FIRST  = 2'd0;
    localparam logic [1:0] GAP_SLOT_SECOND = 2'd1;
    localparam logic [1:0] GAP_SLOT_THIRD  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_SHORT  = 3'd0,
        CFG_PERIOD_MEDIUM = 3'd1,
        CFG_PERIOD_LONG   = 3'd2,
        CFG_PULSE_WIDTH   = 3'd3,
        CFG_GAP_PATTERN   = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BYTE_W-1:0] data;
    } item_t;

    // Interval timing as seen by the back end, with the pulse start of
    // each period already worked out.
    typedef struct packed {
        logic [PERIOD_W-1:0] period_short;
        logic [PERIOD_W-1:0] period_medium;
        logic [PERIOD_W-1:0] period_long;
        logic [PERIOD_W-1:0] start_short;
        logic [PERIOD_W-1:0] start_medium;
        logic [PERIOD_W-1:0] start_long;
        logic [GAP_W-1:0]    gap_pattern;
    } timing_t;

endpackage

[design/mfm_flux_interval_streamer_top.sv]
// Channel   Handshake                   Payload
// request   item_valid / item_stall     action, data_byte
// result    result_valid / result_stall accepted, fill_level, time_code,
//                                       pulse_start, interval_length, from_gap
// config    cfg_write                   cfg_index, cfg_data
//
// One request is taken every cycle while the queue has room. A request accepted into
// the two-entry queue waits there until it is loaded into the result register, and
// its result is held there until it is taken.
// The back end does at most one ring buffer access per request, so the single-port
// ring memory allows one request per cycle while the result is not stalled.
// Reset clears pointers, counters and the queue at once; ring contents are
// undefined until pushed, and no clearing pass is run.
// A stalled result holds the back end, and item_stall rises once the queue fills.
module mfm_flux_interval_streamer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           action,
    input  logic [mfi_pkg::BYTE_W-1:0]     data_byte,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           accepted,
    output logic [mfi_pkg::CNT_W-1:0]      fill_level,
    output logic [mfi_pkg::CODE_W-1:0]     time_code,
    output logic [mfi_pkg::PERIOD_W-1:0]   pulse_start,
    output logic [mfi_pkg::PERIOD_W-1:0]   interval_length,
    output logic                           from_gap,
    input  logic                           cfg_write,
    input  logic [mfi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mfi_pkg::*;

    logic    queue_full;
    logic    queue_push;
    item_t   queue_item;
    logic    head_valid;
    item_t   head_item;
    logic    pop;
    timing_t timing;

    mfi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .action     (action),
        .data_byte  (data_byte),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .queue_push (queue_push),
        .queue_item (queue_item),
        .timing     (timing)
    );

    mfi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_item  (queue_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mfi_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .pop             (pop),
        .timing          (timing),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .accepted        (accepted),
        .fill_level      (fill_level),
        .time_code       (time_code),
        .pulse_start     (pulse_start),
        .interval_length (interval_length),
        .from_gap        (from_gap)
    );

endmodule

[design/mfi_front.sv]
module mfi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          action,
    input  logic [mfi_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          cfg_write,
    input  logic [mfi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          queue_full,
    output logic                          queue_push,
    output mfi_pkg::item_t                queue_item,
    output mfi_pkg::timing_t              timing
);
    import mfi_pkg::*;

    logic [PERIOD_W-1:0] period_short_reg;
    logic [PERIOD_W-1:0] period_medium_reg;
    logic [PERIOD_W-1:0] period_long_reg;
    logic [PULSE_W-1:0]  pulse_width_reg;
    logic [GAP_W-1:0]    gap_pattern_reg;
    logic [PERIOD_W-1:0] start_short_reg;
    logic [PERIOD_W-1:0] start_medium_reg;
    logic [PERIOD_W-1:0] start_long_reg;
    logic [PERIOD_W-1:0] start_short_next;
    logic [PERIOD_W-1:0] start_medium_next;
    logic [PERIOD_W-1:0] start_long_next;
    logic [PERIOD_W-1:0] pulse_ext;

    // Requests only wait on queue space.
    assign item_stall = queue_full;
    assign queue_push = item_valid && !queue_full;

    always_comb
    begin
        queue_item.op   = action ? OP_TICK : OP_PUSH;
        queue_item.data = data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_short_reg  <= PERIOD_SHORT_RST;
            period_medium_reg <= PERIOD_MEDIUM_RST;
            period_long_reg   <= PERIOD_LONG_RST;
            pulse_width_reg   <= PULSE_WIDTH_RST;
            gap_pattern_reg   <= GAP_PATTERN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PERIOD_SHORT:  period_short_reg  <= cfg_data[PERIOD_W-1:0];
                CFG_PERIOD_MEDIUM: period_medium_reg <= cfg_data[PERIOD_W-1:0];
                CFG_PERIOD_LONG:   period_long_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_PULSE_WIDTH:   pulse_width_reg   <= cfg_data[PULSE_W-1:0];
                CFG_GAP_PATTERN:   gap_pattern_reg   <= cfg_data[GAP_W-1:0];
                default:           ;
            endcase
        end
    end

    // The pulse start saturates at zero when the pulse is wider than the period.
    assign pulse_ext = {{(PERIOD_W-PULSE_W){1'b0}}, pulse_width_reg};

    always_comb
    begin
        start_short_next  = (period_short_reg > pulse_ext) ?
                            period_short_reg - pulse_ext : '0;
        start_medium_next = (period_medium_reg > pulse_ext) ?
                            period_medium_reg - pulse_ext : '0;
        start_long_next   = (period_long_reg > pulse_ext) ?
                            period_long_reg - pulse_ext : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_short_reg  <= START_SHORT_RST;
            start_medium_reg <= START_MEDIUM_RST;
            start_long_reg   <= START_LONG_RST;
        end
        else
        begin
            start_short_reg  <= start_short_next;
            start_medium_reg <= start_medium_next;
            start_long_reg   <= start_long_next;
        end
    end

    always_comb
    begin
        timing.period_short  = period_short_reg;
        timing.period_medium = period_medium_reg;
        timing.period_long   = period_long_reg;
        timing.start_short   = start_short_reg;
        timing.start_medium  = start_medium_reg;
        timing.start_long    = start_long_reg;
        timing.gap_pattern   = gap_pattern_reg;
    end

endmodule

[design/mfi_queue.sv]
module mfi_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mfi_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mfi_pkg::item_t head_item
);
    import mfi_pkg::*;

    item_t      entry_reg [2];
    logic       wr_sel_reg;
    logic       rd_sel_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_sel_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_sel_reg <= !wr_sel_reg;
            end
            if (pop)
            begin
                rd_sel_reg <= !rd_sel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_sel_reg] <= push_item;
        end
    end

endmodule

[design/mfi_back.sv]
module mfi_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  mfi_pkg::item_t                head_item,
    output logic                          pop,
    input  mfi_pkg::timing_t              timing,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          accepted,
    output logic [mfi_pkg::CNT_W-1:0]     fill_level,
    output logic [mfi_pkg::CODE_W-1:0]    time_code,
    output logic [mfi_pkg::PERIOD_W-1:0]  pulse_start,
    output logic [mfi_pkg::PERIOD_W-1:0]  interval_length,
    output logic                          from_gap
);
    import mfi_pkg::*;

    logic [BYTE_W-1:0] ring_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              load_pending_reg, load_pending_next;
    logic [1:0]        code_pos_reg, code_pos_next;
    logic [1:0]        gap_pos_reg, gap_pos_next;

    logic              result_valid_reg;
    logic              accepted_reg, accepted_next;
    logic [CNT_W-1:0]  fill_level_reg;
    logic [CODE_W-1:0] time_code_reg, time_code_next;
    logic [PERIOD_W-1:0] pulse_start_reg, pulse_start_next;
    logic [PERIOD_W-1:0] length_reg, length_next;
    logic              from_gap_reg, from_gap_next;

    logic              mem_write;
    logic              mem_read;
    logic [BYTE_W-1:0] shift_cur;
    logic [CODE_W-1:0] code;
    logic [1:0]        gap_sel;
    logic [BYTE_W-1:0] gap_byte;

    // One item is carried out per cycle whenever the result register is free.
    assign pop = head_valid && (!result_valid_reg || !result_stall);

    // A byte fetched from the ring lands in the read register, and the next
    // tick takes its codes straight from there.
    assign shift_cur = load_pending_reg ? rd_data_reg : shift_reg;
    assign code      = shift_cur[BYTE_W-1 -: CODE_W];
    assign gap_sel   = (gap_pos_reg == LAST_CODE_POS) ? GAP_SLOT_FIRST : gap_pos_reg;

    always_comb
    begin
        case (gap_sel)
            GAP_SLOT_SECOND: gap_byte = timing.gap_pattern[2*BYTE_W-1 -: BYTE_W];
            GAP_SLOT_THIRD:  gap_byte = timing.gap_pattern[BYTE_W-1 -: BYTE_W];
            default:         gap_byte = timing.gap_pattern[3*BYTE_W-1 -: BYTE_W];
        endcase
    end

    always_comb
    begin
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        fill_next         = fill_reg;
        shift_next        = shift_reg;
        load_pending_next = load_pending_reg;
        code_pos_next     = code_pos_reg;
        gap_pos_next      = gap_pos_reg;
        mem_write         = 1'b0;
        mem_read          = 1'b0;
        accepted_next     = 1'b0;
        time_code_next    = '0;
        pulse_start_next  = '0;
        length_next       = '0;
        from_gap_next     = 1'b0;

        if (pop)
        begin
            unique case (head_item.op)
                OP_PUSH:
                begin
                    if (fill_reg != CNT_W'(BUF_DEPTH))
                    begin
                        mem_write     = 1'b1;
                        accepted_next = 1'b1;
                        fill_next     = fill_reg + CNT_W'(1);
                        wr_ptr_next   = (wr_ptr_reg == PTR_W'(BUF_DEPTH - 1)) ?
                                        '0 : wr_ptr_reg + PTR_W'(1);
                    end
                end
                OP_TICK:
                begin
                    time_code_next    = code;
                    code_pos_next     = code_pos_reg + 2'd1;
                    shift_next        = {shift_cur[BYTE_W-CODE_W-1:0], {CODE_W{1'b0}}};
                    load_pending_next = 1'b0;
                    case (code)
                        CODE_LONG:
                        begin
                            length_next      = timing.period_long;
                            pulse_start_next = timing.start_long;
                        end
                        CODE_MEDIUM:
                        begin
                            length_next      = timing.period_medium;
                            pulse_start_next = timing.start_medium;
                        end
                        default:
                        begin
                            length_next      = timing.period_short;
                            pulse_start_next = timing.start_short;
                        end
                    endcase
                    if (code_pos_reg == LAST_CODE_POS)
                    begin
                        if (fill_reg == '0)
                        begin
                            shift_next    = gap_byte;
                            gap_pos_next  = (gap_sel == GAP_SLOT_THIRD) ?
                                            GAP_SLOT_FIRST : gap_sel + 2'd1;
                            from_gap_next = 1'b1;
                        end
                        else
                        begin
                            mem_read          = 1'b1;
                            load_pending_next = 1'b1;
                            fill_next         = fill_reg - CNT_W'(1);
                            rd_ptr_next       = (rd_ptr_reg == PTR_W'(BUF_DEPTH - 1)) ?
                                                '0 : rd_ptr_reg + PTR_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_write)
        begin
            ring_mem[wr_ptr_reg] <= head_item.data;
        end
        if (mem_read)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            fill_reg         <= '0;
            shift_reg        <= '0;
            load_pending_reg <= 1'b0;
            code_pos_reg     <= '0;
            gap_pos_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            fill_reg         <= fill_next;
            shift_reg        <= shift_next;
            load_pending_reg <= load_pending_next;
            code_pos_reg     <= code_pos_next;
            gap_pos_reg      <= gap_pos_next;
            if (pop)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            accepted_reg    <= accepted_next;
            fill_level_reg  <= fill_next;
            time_code_reg   <= time_code_next;
            pulse_start_reg <= pulse_start_next;
            length_reg      <= length_next;
            from_gap_reg    <= from_gap_next;
        end
    end

    assign result_valid    = result_valid_reg;
    assign accepted        = accepted_reg;
    assign fill_level      = fill_level_reg;
    assign time_code       = time_code_reg;
    assign pulse_start     = pulse_start_reg;
    assign interval_length = length_reg;
    assign from_gap        = from_gap_reg;

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfi_pkg::*;

    // Codes 0 and 1 both select the short interval.
    localparam logic [CODE_W-1:0] CODE_SHORT     = 2'd0;
    localparam logic [CODE_W-1:0] CODE_SHORT_ALT = 2'd1;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 25;

    typedef struct packed {
        logic                accepted;
        logic [CNT_W-1:0]    fill;
        logic [CODE_W-1:0]   code;
        logic [PERIOD_W-1:0] start;
        logic [PERIOD_W-1:0] length;
        logic                gap;
    } interval_result_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic              typed;
        interval_result_t  result;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    logic                  action = 1'b0;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  accepted;
    logic [CNT_W-1:0]      fill_level;
    logic [CODE_W-1:0]     time_code;
    logic [PERIOD_W-1:0]   pulse_start;
    logic [PERIOD_W-1:0]   interval_length;
    logic                  from_gap;
    logic                  cfg_write = 1'b0;
    cfg_index_t            cfg_index = CFG_PERIOD_SHORT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mfm_flux_interval_streamer_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .action          (action),
        .data_byte       (data_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .accepted        (accepted),
        .fill_level      (fill_level),
        .time_code       (time_code),
        .pulse_start     (pulse_start),
        .interval_length (interval_length),
        .from_gap        (from_gap),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Streamer state as predicted from the requests taken so far.
    logic [PERIOD_W-1:0] pred_short  = PERIOD_SHORT_RST;
    logic [PERIOD_W-1:0] pred_medium = PERIOD_MEDIUM_RST;
    logic [PERIOD_W-1:0] pred_long   = PERIOD_LONG_RST;
    logic [PULSE_W-1:0]  pred_pulse  = PULSE_WIDTH_RST;
    logic [GAP_W-1:0]    pred_gap    = GAP_PATTERN_RST;
    logic [BYTE_W-1:0]   pred_ring [BUF_DEPTH];
    int                  pred_rd = 0;
    int                  pred_wr = 0;
    int                  pred_level = 0;
    logic [BYTE_W-1:0]   pred_shift = '0;
    logic [1:0]          pred_slot = '0;
    logic [1:0]          pred_gap_slot = GAP_SLOT_FIRST;

    interval_result_t expected_intervals [$];

    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int pushes_refused = 0;
    int gap_loads = 0;
    int register_writes = 0;
    int sender_burst = 0;
    int hold_cycles_req = 0;
    int receiver_left = 0;
    logic receiver_stalling = 1'b0;
    int receiver_roll;
    int idle_cycles = 0;

    // The first rows walk the gap pattern straight out of reset; the rest are
    // checked against the predictor.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_TICK, 8'h00, 1'b1, '{1'b0, 13'd0, CODE_SHORT, START_SHORT_RST,
            PERIOD_SHORT_RST, 1'b0}},
        '{OP_TICK, 8'hFF, 1'b1, '{1'b0, 13'd0, CODE_SHORT, START_SHORT_RST,
            PERIOD_SHORT_RST, 1'b0}},
        '{OP_TICK, 8'h00, 1'b1, '{1'b0, 13'd0, CODE_SHORT, START_SHORT_RST,
            PERIOD_SHORT_RST, 1'b0}},
        '{OP_TICK, 8'h00, 1'b1, '{1'b0, 13'd0, CODE_SHORT, START_SHORT_RST,
            PERIOD_SHORT_RST, 1'b1}},
        '{OP_TICK, 8'h00, 1'b1, '{1'b0, 13'd0, CODE_MEDIUM, START_MEDIUM_RST,
            PERIOD_MEDIUM_RST, 1'b0}},
        '{OP_TICK, 8'h00, 1'b1, '{1'b0, 13'd0, CODE_MEDIUM, START_MEDIUM_RST,
            PERIOD_MEDIUM_RST, 1'b0}},
        '{OP_TICK, 8'h00, 1'b1, '{1'b0, 13'd0, CODE_MEDIUM, START_MEDIUM_RST,
            PERIOD_MEDIUM_RST, 1'b0}},
        '{OP_TICK, 8'h00, 1'b1, '{1'b0, 13'd0, CODE_SHORT_ALT, START_SHORT_RST,
            PERIOD_SHORT_RST, 1'b1}},
        '{OP_PUSH, 8'hFF, 1'b0, '0},
        '{OP_PUSH, 8'h00, 1'b0, '0},
        '{OP_PUSH, 8'hE4, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0}
    };

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advances the predicted streamer by one request and returns its result.
    function automatic interval_result_t step_streamer(op_t op, logic [BYTE_W-1:0] data);
        interval_result_t r;
        logic [CODE_W-1:0] code;
        logic [PERIOD_W-1:0] length;
        logic [GAP_W-1:0] shifted;
        r = '0;
        if (op == OP_PUSH)
        begin
            if (pred_level < BUF_DEPTH)
            begin
                pred_ring[pred_wr] = data;
                pred_wr = (pred_wr == BUF_DEPTH - 1) ? 0 : pred_wr + 1;
                pred_level++;
                r.accepted = 1'b1;
            end
        end
        else
        begin
            code = pred_shift[7:6];
            pred_shift = pred_shift << 2;
            pred_slot = pred_slot + 2'd1;
            if (code == CODE_LONG)
                length = pred_long;
            else if (code == CODE_MEDIUM)
                length = pred_medium;
            else
                length = pred_short;
            r.code = code;
            r.length = length;
            r.start = (length > pred_pulse) ? length - pred_pulse : '0;
            // The fourth code of a byte pulls in the next byte.
            if (pred_slot == '0)
            begin
                if (pred_level == 0)
                begin
                    shifted = pred_gap >> (16 - 8 * pred_gap_slot);
                    pred_shift = shifted[7:0];
                    pred_gap_slot = (pred_gap_slot == GAP_SLOT_THIRD) ? GAP_SLOT_FIRST
                                                                      : pred_gap_slot + 2'd1;
                    r.gap = 1'b1;
                end
                else
                begin
                    pred_shift = pred_ring[pred_rd];
                    pred_rd = (pred_rd == BUF_DEPTH - 1) ? 0 : pred_rd + 1;
                    pred_level--;
                end
            end
        end
        r.fill = pred_level[CNT_W-1:0];
        return r;
    endfunction

    task automatic send_request(input op_t op, input logic [BYTE_W-1:0] data,
                                input logic typed, input interval_result_t typed_result);
        interval_result_t predicted;
        item_valid <= 1'b1;
        action <= op;
        data_byte <= data;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = step_streamer(op, data);
        expected_intervals.push_back(typed ? typed_result : predicted);
        requests_sent++;
        if (op == OP_PUSH && !predicted.accepted)
            pushes_refused++;
        if (predicted.gap)
            gap_loads++;
    endtask

    task automatic pause_sender();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (sender_burst != 0)
        begin
            sender_burst--;
            gap = 0;
        end
        else if (roll < 3)
        begin
            sender_burst = $urandom_range(30, 80);
            gap = 0;
        end
        else if (roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(15, 40);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(input int push_pct);
        pause_sender();
        send_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_TICK,
                     8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic wait_for_idle();
        item_valid <= 1'b0;
        while (expected_intervals.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PERIOD_SHORT:  pred_short = value[PERIOD_W-1:0];
            CFG_PERIOD_MEDIUM: pred_medium = value[PERIOD_W-1:0];
            CFG_PERIOD_LONG:   pred_long = value[PERIOD_W-1:0];
            CFG_PULSE_WIDTH:   pred_pulse = value[PULSE_W-1:0];
            CFG_GAP_PATTERN:   pred_gap = value;
            default: ;
        endcase
        register_writes++;
    endtask

    // Short periods are favored so that the pulse often swallows the whole interval.
    function automatic logic [CFG_DATA_W-1:0] pick_period();
        if ($urandom_range(0, 1) == 0)
            return CFG_DATA_W'($urandom_range(1, 300));
        return CFG_DATA_W'($urandom_range(1, 65535));
    endfunction

    task automatic write_random_settings();
        write_register(CFG_PERIOD_SHORT, pick_period());
        write_register(CFG_PERIOD_MEDIUM, pick_period());
        write_register(CFG_PERIOD_LONG, pick_period());
        write_register(CFG_PULSE_WIDTH, CFG_DATA_W'($urandom_range(0, 255)));
        write_register(CFG_GAP_PATTERN, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // Result monitor: every accepted result is matched with the oldest expectation.
    always @(posedge clk)
    begin
        interval_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_intervals.size() == 0)
            begin
                error_count++;
                $display("%0t: result arrived with no request outstanding", $time);
            end
            else
            begin
                want = expected_intervals.pop_front();
                check_field("accepted", 16'(want.accepted), 16'(accepted));
                check_field("fill_level", 16'(want.fill), 16'(fill_level));
                check_field("time_code", 16'(want.code), 16'(time_code));
                check_field("pulse_start", want.start, pulse_start);
                check_field("interval_length", want.length, interval_length);
                check_field("from_gap", 16'(want.gap), 16'(from_gap));
                results_checked++;
            end
        end
    end

    // Result side back-pressure: short and long stalls, free-running stretches,
    // and on request one long hold-off that backs the block up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles_req != 0)
            begin
                receiver_stalling = 1'b1;
                receiver_left = hold_cycles_req;
                hold_cycles_req = 0;
            end
            else if (receiver_left == 0)
            begin
                receiver_roll = $urandom_range(0, 99);
                if (receiver_roll < 15)
                begin
                    receiver_stalling = 1'b0;
                    receiver_left = $urandom_range(20, 80);
                end
                else if (receiver_roll < 20)
                begin
                    receiver_stalling = 1'b1;
                    receiver_left = $urandom_range(15, 40);
                end
                else if (receiver_roll < 60)
                begin
                    receiver_stalling = 1'b1;
                    receiver_left = $urandom_range(1, 3);
                end
                else
                begin
                    receiver_stalling = 1'b0;
                    receiver_left = $urandom_range(1, 6);
                end
            end
            receiver_left--;
            result_stall <= receiver_stalling;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request or result moved for %0d cycles", $time,
                         WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            pause_sender();
            send_request(directed_rows[k].op, directed_rows[k].data,
                         directed_rows[k].typed, directed_rows[k].result);
        end
        wait_for_idle();

        // Range ends, but the long period is set equal to the pulse width.
        write_register(CFG_PERIOD_SHORT, CFG_DATA_W'(1));
        write_register(CFG_PERIOD_MEDIUM, CFG_DATA_W'(65535));
        write_register(CFG_PERIOD_LONG, CFG_DATA_W'(255));
        write_register(CFG_PULSE_WIDTH, CFG_DATA_W'(255));
        write_register(CFG_GAP_PATTERN, 24'hFFFFFF);
        repeat (350) send_random(25);
        wait_for_idle();

        write_register(CFG_PERIOD_SHORT, CFG_DATA_W'(65535));
        write_register(CFG_PERIOD_MEDIUM, CFG_DATA_W'(1));
        write_register(CFG_PERIOD_LONG, CFG_DATA_W'(65535));
        write_register(CFG_PULSE_WIDTH, CFG_DATA_W'(0));
        write_register(CFG_GAP_PATTERN, 24'h000000);
        repeat (350) send_random(20);
        wait_for_idle();

        write_random_settings();
        repeat (150) send_random(50);
        // Results are held off while requests keep coming with no gaps.
        hold_cycles_req = HOLD_CYCLES;
        repeat (60)
            send_request(($urandom_range(0, 1) == 0) ? OP_PUSH : OP_TICK,
                         8'($urandom_range(0, 255)), 1'b0, '0);
        repeat (150) send_random(50);
        wait_for_idle();

        write_random_settings();
        repeat (350) send_random(10);
        wait_for_idle();

        write_register(CFG_PERIOD_SHORT, CFG_DATA_W'(PERIOD_SHORT_RST));
        write_register(CFG_PERIOD_MEDIUM, CFG_DATA_W'(PERIOD_MEDIUM_RST));
        write_register(CFG_PERIOD_LONG, CFG_DATA_W'(PERIOD_LONG_RST));
        write_register(CFG_PULSE_WIDTH, CFG_DATA_W'(PULSE_WIDTH_RST));
        write_register(CFG_GAP_PATTERN, CFG_DATA_W'(GAP_PATTERN_RST));
        repeat (350) send_random(30);
        wait_for_idle();
        repeat (10) @(posedge clk);

        $display("Sent %0d requests and checked %0d results over %0d register writes.",
                 requests_sent, results_checked, register_writes);
        $display("Pushes refused: %0d; bytes taken from the gap pattern: %0d.",
                 pushes_refused, gap_loads);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
